// File: rtl/tfn_pkg.sv
// Shared constant and width helper for the triangle face normal block.
package tfn_pkg;

    // Width of each normal component on the result ports.
    localparam int OUT_WIDTH = 16;

    // Signed width of one cross product component for a given coordinate width.
    function automatic int cross_width(input int coord_width);
        begin
            cross_width = 2 * coord_width + 3;
        end
    endfunction

endpackage

// File: rtl/triangle_face_normal.sv
// Top level: unit surface normal of one triangle, Q1.14 rounded to nearest.
// The path from start to done runs through six front stages, one rounding cell per
// result bit and one output register.
// Throughput is one request per cycle; busy is always low, since every stage
// advances each cycle and the receiver cannot stall the done strobe.
// Reset clears only the valid pipeline, so done stays low after reset.
module triangle_face_normal #(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
    output logic done,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_x,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_y,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_z,
    output logic degenerate
);
    import tfn_pkg::*;

    localparam int F   = NORMAL_FRAC_BITS;
    localparam int WW  = cross_width(COORD_WIDTH);
    localparam int MW  = WW - 1;
    localparam int SW  = 2 * MW + 2;
    localparam int RW  = 2 * MW + 2 * F + 2;
    localparam int XW  = 2 * MW + 2 * F + 8;
    localparam int NL  = F + 1;
    localparam int QEW = (F + 2 > OUT_WIDTH) ? F + 2 : OUT_WIDTH;

    logic signed [COORD_WIDTH-1:0] va [3];
    logic signed [COORD_WIDTH-1:0] vb [3];
    logic signed [COORD_WIDTH-1:0] vc [3];

    logic front_valid;
    logic front_degenerate;
    logic [SW-1:0] len_sq;
    logic [RW-1:0] rhs [3];
    logic comp_neg [3];

    // Each component walks through its own row of cells; s travels with it.
    logic [SW-1:0] s_ch [3][NL+1];
    logic signed [XW-1:0] d_ch [3][NL+1];
    logic signed [XW-1:0] t_ch [3][NL+1];
    logic [F:0] q_ch [3][NL+1];
    logic neg_ch [3][NL+1];

    // Valid and degenerate ride alongside the cell rows.
    logic [NL-1:0] valid_line_reg;
    logic [NL-1:0] degen_line_reg;

    logic done_reg;
    logic degenerate_reg;
    logic signed [OUT_WIDTH-1:0] normal_reg [3];

    assign va[0] = vertex_a_x;
    assign va[1] = vertex_a_y;
    assign va[2] = vertex_a_z;
    assign vb[0] = vertex_b_x;
    assign vb[1] = vertex_b_y;
    assign vb[2] = vertex_b_z;
    assign vc[0] = vertex_c_x;
    assign vc[1] = vertex_c_y;
    assign vc[2] = vertex_c_z;

    // Every stage moves each cycle, so a new request is always welcome.
    assign busy = 1'b0;

    tfn_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start),
        .va             (va),
        .vb             (vb),
        .vc             (vc),
        .out_valid      (front_valid),
        .out_degenerate (front_degenerate),
        .len_sq         (len_sq),
        .rhs            (rhs),
        .comp_neg       (comp_neg)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_row
        // The search starts from q = 0, where the odd number 2q-1 is -1:
        // the remainder is rhs - s and the running product is -s.
        assign s_ch[c][0]   = len_sq;
        assign d_ch[c][0]   = $signed(XW'(rhs[c])) - $signed(XW'(len_sq));
        assign t_ch[c][0]   = -$signed(XW'(len_sq));
        assign q_ch[c][0]   = '0;
        assign neg_ch[c][0] = comp_neg[c];

        for (genvar i = 0; i < NL; i++)
        begin : g_cell
            tfn_cell #(
                .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
                .BIT              (F - i),
                .SW               (SW),
                .XW               (XW)
            ) u_cell (
                .clk     (clk),
                .s_in    (s_ch[c][i]),
                .d_in    (d_ch[c][i]),
                .t_in    (t_ch[c][i]),
                .q_in    (q_ch[c][i]),
                .neg_in  (neg_ch[c][i]),
                .s_out   (s_ch[c][i+1]),
                .d_out   (d_ch[c][i+1]),
                .t_out   (t_ch[c][i+1]),
                .q_out   (q_ch[c][i+1]),
                .neg_out (neg_ch[c][i+1])
            );
        end

        // Apply the sign, keep the low bits of the component and force zero when degenerate.
        logic signed [F+1:0] q_signed;
        logic signed [QEW-1:0] q_wide;
        assign q_signed = neg_ch[c][NL] ? -$signed({1'b0, q_ch[c][NL]})
                                        : $signed({1'b0, q_ch[c][NL]});
        assign q_wide   = QEW'(q_signed);

        always_ff @(posedge clk)
        begin
            normal_reg[c] <= degen_line_reg[NL-1] ? '0 : q_wide[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_line_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            valid_line_reg <= {valid_line_reg[NL-2:0], front_valid};
            done_reg       <= valid_line_reg[NL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        degen_line_reg <= {degen_line_reg[NL-2:0], front_degenerate};
        degenerate_reg <= degen_line_reg[NL-1];
    end

    assign done       = done_reg;
    assign degenerate = degenerate_reg;
    assign normal_x   = normal_reg[0];
    assign normal_y   = normal_reg[1];
    assign normal_z   = normal_reg[2];

endmodule

// File: rtl/tfn_front.sv
// Front pipeline: edges, cross product, squared length and scaled squares.
module tfn_front #(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [COORD_WIDTH-1:0] va [3],
    input  logic signed [COORD_WIDTH-1:0] vb [3],
    input  logic signed [COORD_WIDTH-1:0] vc [3],
    output logic out_valid,
    output logic out_degenerate,
    output logic [2*(tfn_pkg::cross_width(COORD_WIDTH)-1)+1:0] len_sq,
    output logic [2*(tfn_pkg::cross_width(COORD_WIDTH)-1)+2*NORMAL_FRAC_BITS+1:0] rhs [3],
    output logic comp_neg [3]
);
    import tfn_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int WW = cross_width(CW);
    localparam int MW = WW - 1;
    localparam int KL = MW / 2;
    localparam int KH = MW - KL;
    localparam int SQW = 2 * MW;
    localparam int SW = SQW + 2;
    localparam int RW = SQW + 2 * F + 2;

    logic [5:0] valid_reg;

    logic signed [EW-1:0] u_reg [3];
    logic signed [EW-1:0] v_reg [3];
    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];
    logic [MW-1:0] mag_reg [3];
    logic neg_reg [3];
    logic neg4_reg [3];
    logic neg5_reg [3];
    logic neg6_reg [3];
    logic [2*KH-1:0] hh_reg [3];
    logic [KH+KL-1:0] hl_reg [3];
    logic [2*KL-1:0] ll_reg [3];
    logic [SQW-1:0] sq_reg [3];
    logic [SW-1:0] s_reg;
    logic [RW-1:0] rhs_reg [3];
    logic zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_comp
        localparam int C1 = (c + 1) % 3;
        localparam int C2 = (c + 2) % 3;
        logic signed [WW-1:0] w;

        assign w = WW'(pa_reg[c]) - WW'(pb_reg[c]);

        always_ff @(posedge clk)
        begin
            u_reg[c]  <= EW'(vb[c]) - EW'(va[c]);
            v_reg[c]  <= EW'(vc[c]) - EW'(vb[c]);
            pa_reg[c] <= u_reg[C1] * v_reg[C2];
            pb_reg[c] <= u_reg[C2] * v_reg[C1];
            neg_reg[c] <= w[WW-1];
            mag_reg[c] <= w[WW-1] ? MW'(-w) : MW'(w);
            hh_reg[c] <= mag_reg[c][MW-1:KL] * mag_reg[c][MW-1:KL];
            hl_reg[c] <= mag_reg[c][MW-1:KL] * mag_reg[c][KL-1:0];
            ll_reg[c] <= mag_reg[c][KL-1:0] * mag_reg[c][KL-1:0];
            neg4_reg[c] <= neg_reg[c];
            sq_reg[c] <= (SQW'(hh_reg[c]) << (2 * KL)) + (SQW'(hl_reg[c]) << (KL + 1))
                       + SQW'(ll_reg[c]);
            neg5_reg[c] <= neg4_reg[c];
            rhs_reg[c] <= RW'(sq_reg[c]) << (2 * F + 2);
            neg6_reg[c] <= neg5_reg[c];
        end

        assign rhs[c]      = rhs_reg[c];
        assign comp_neg[c] = neg6_reg[c];
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        zero_reg <= (sq_reg[0] == '0) && (sq_reg[1] == '0) && (sq_reg[2] == '0);
    end

    assign out_valid      = valid_reg[5];
    assign out_degenerate = zero_reg;
    assign len_sq         = s_reg;

endmodule

// File: rtl/tfn_cell.sv
// One cell of the rounding chain: decides one bit of one normal component.
module tfn_cell #(
    parameter int NORMAL_FRAC_BITS = 14,
    parameter int BIT              = 14,
    parameter int SW               = 102,
    parameter int XW               = 136
) (
    input  logic clk,
    input  logic [SW-1:0] s_in,
    input  logic signed [XW-1:0] d_in,
    input  logic signed [XW-1:0] t_in,
    input  logic [NORMAL_FRAC_BITS:0] q_in,
    input  logic neg_in,
    output logic [SW-1:0] s_out,
    output logic signed [XW-1:0] d_out,
    output logic signed [XW-1:0] t_out,
    output logic [NORMAL_FRAC_BITS:0] q_out,
    output logic neg_out
);
    import tfn_pkg::*;

    localparam int F = NORMAL_FRAC_BITS;

    logic signed [XW-1:0] s_ext;
    logic signed [XW-1:0] trial;
    logic take;

    logic [SW-1:0] s_reg;
    logic signed [XW-1:0] d_reg;
    logic signed [XW-1:0] t_reg;
    logic [F:0] q_reg;
    logic neg_reg;

    // The odd number 2q-1 grows by 2^(BIT+1); its square times s grows by
    // 2^(BIT+2)*t + 2^(2*BIT+2)*s, where t tracks (2q-1)*s.
    assign s_ext = $signed(XW'(s_in));
    assign trial = d_in - ((t_in <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2)));
    assign take  = !q_in[F] && !trial[XW-1];

    always_ff @(posedge clk)
    begin
        s_reg   <= s_in;
        neg_reg <= neg_in;
        d_reg   <= take ? trial : d_in;
        t_reg   <= take ? (t_in + (s_ext <<< (BIT + 1))) : t_in;
        q_reg   <= take ? (q_in | ((F + 1)'(1) << BIT)) : q_in;
    end

    assign s_out   = s_reg;
    assign d_out   = d_reg;
    assign t_out   = t_reg;
    assign q_out   = q_reg;
    assign neg_out = neg_reg;

endmodule
